/* sv/lztd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lztd_pkg: shared types and constants of the lz77 token decoder
// Request and result structs, token phase and controller state encodings,
// and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package lztd_pkg;

    localparam int HIST_DEPTH  = 256;
    localparam int HIST_AW     = $clog2(HIST_DEPTH);
    localparam int CNT_W       = HIST_AW + 1;
    localparam int OUT_LANES   = 4;
    localparam int LANE_IDX_W  = $clog2(OUT_LANES);
    localparam int LANE_CNT_W  = $clog2(OUT_LANES + 1);
    localparam int LEN_W       = 7;
    localparam int WORD_W      = 8 * OUT_LANES;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       segment_start;
    } req_item_t;

    typedef struct packed {
        logic [WORD_W-1:0]     out_bytes;
        logic [LANE_CNT_W-1:0] byte_count;
        logic                  bad_reference;
        logic                  last;
    } res_item_t;

    typedef enum logic [1:0] {
        PH_HDR_LO  = 2'd0,
        PH_HDR_HI  = 2'd1,
        PH_LITERAL = 2'd2
    } token_phase_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_READ  = 2'd1,
        ST_WRITE = 2'd2,
        ST_EMIT  = 2'd3
    } ctrl_state_t;

    typedef struct packed {
        logic take;
        logic rd;
        logic wr;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic copy_go;
        logic group_done;
        logic copy_done;
    } dpath_stat_t;

endpackage

/* sv/lztd_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lztd_ctrl: controller of the lz77 token decoder
// Accepts requests while idle and sequences the read, write and emit steps
// of a back-reference copy.
// ----------------------------------------------------------------------------
module lztd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  lztd_pkg::dpath_stat_t stat,
    output lztd_pkg::ctrl_cmd_t  cmd
);
    import lztd_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall = !stat.out_free;
                cmd.take  = req_valid && stat.out_free;
                if (cmd.take && stat.copy_go)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                cmd.wr     = 1'b1;
                state_next = stat.group_done ? ST_EMIT : ST_READ;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = stat.copy_done ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // no request is taken while a copy is in flight
    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> req_stall)
        else $error("request accepted during copy");

    // every history read is followed by its write
    a_read_then_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> (state_reg == ST_WRITE))
        else $error("read not followed by write");

endmodule

/* sv/lztd_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lztd_dpath: datapath of the lz77 token decoder
// Token phase and header registers, history ring buffer, copy pointers,
// lane packing and the result register.
// ----------------------------------------------------------------------------
module lztd_dpath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lztd_pkg::req_item_t  req_data,
    input  lztd_pkg::ctrl_cmd_t  cmd,
    output lztd_pkg::dpath_stat_t stat,
    output logic                 res_valid,
    input  logic                 res_stall,
    output lztd_pkg::res_item_t  res_data
);
    import lztd_pkg::*;

    logic [7:0]            hist_mem [HIST_DEPTH];

    token_phase_t          phase_reg;
    logic [7:0]            header_low_reg;
    logic [HIST_AW-1:0]    wp_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [HIST_AW-1:0]    src_reg;
    logic [LEN_W-1:0]      remain_reg;
    logic [7:0]            rdata_reg;
    logic [WORD_W-1:0]     word_reg;
    logic [LANE_CNT_W-1:0] lane_reg;
    logic                  res_valid_reg;
    res_item_t             res_reg;

    token_phase_t          phase_eff;
    logic [HIST_AW-1:0]    back_dist;
    logic [LEN_W-1:0]      len;
    logic                  bad_dist;
    logic                  is_copy_hdr;
    logic                  lit_take;
    logic                  bad_take;
    logic                  push;
    res_item_t             res_next;
    logic                  hist_we;
    logic [7:0]            hist_wdata;
    logic [CNT_W-1:0]      count_inc;

    always_comb
    begin
        phase_eff   = req_data.segment_start ? PH_HDR_LO : phase_reg;
        back_dist   = {req_data.in_byte[6:0], header_low_reg[7]};
        len         = header_low_reg[LEN_W-1:0];
        bad_dist    = (back_dist == '0) || ({1'b0, back_dist} > count_reg);
        is_copy_hdr = (phase_eff == PH_HDR_HI) && req_data.in_byte[7];
        lit_take    = cmd.take && (phase_eff == PH_LITERAL);
        bad_take    = cmd.take && is_copy_hdr && bad_dist;

        stat.out_free   = !res_valid_reg || !res_stall;
        stat.copy_go    = is_copy_hdr && !bad_dist && (len != '0);
        stat.group_done = (lane_reg == LANE_CNT_W'(OUT_LANES - 1))
                          || (remain_reg == LEN_W'(1));
        stat.copy_done  = (remain_reg == '0);

        count_inc  = (count_reg == CNT_W'(HIST_DEPTH)) ? count_reg
                                                       : count_reg + CNT_W'(1);
        hist_we    = lit_take || cmd.wr;
        hist_wdata = lit_take ? req_data.in_byte : rdata_reg;

        push     = lit_take || bad_take || cmd.emit;
        res_next = '0;
        if (lit_take)
        begin
            res_next.out_bytes  = WORD_W'(req_data.in_byte);
            res_next.byte_count = LANE_CNT_W'(1);
            res_next.last       = 1'b1;
        end
        else if (bad_take)
        begin
            res_next.bad_reference = 1'b1;
            res_next.last          = 1'b1;
        end
        else
        begin
            res_next.out_bytes  = word_reg;
            res_next.byte_count = lane_reg;
            res_next.last       = (remain_reg == '0);
        end
    end

    // history ring buffer, read data registered
    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[wp_reg] <= hist_wdata;
        end
        if (cmd.rd)
        begin
            rdata_reg <= hist_mem[src_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR_LO;
            wp_reg     <= '0;
            count_reg  <= '0;
            remain_reg <= '0;
            lane_reg   <= '0;
        end
        else
        begin
            if (cmd.take)
            begin
                unique case (phase_eff)
                    PH_HDR_HI:
                    begin
                        phase_reg <= req_data.in_byte[7] ? PH_HDR_LO : PH_LITERAL;
                        if (req_data.in_byte[7] && !bad_dist)
                        begin
                            remain_reg <= len;
                        end
                    end
                    PH_LITERAL:
                    begin
                        phase_reg <= PH_HDR_LO;
                        wp_reg    <= wp_reg + HIST_AW'(1);
                        count_reg <= count_inc;
                    end
                    default:
                    begin
                        phase_reg <= PH_HDR_HI;
                        if (req_data.segment_start)
                        begin
                            wp_reg    <= '0;
                            count_reg <= '0;
                        end
                    end
                endcase
            end
            if (cmd.wr)
            begin
                wp_reg     <= wp_reg + HIST_AW'(1);
                count_reg  <= count_inc;
                remain_reg <= remain_reg - LEN_W'(1);
                lane_reg   <= lane_reg + LANE_CNT_W'(1);
            end
            if (cmd.emit)
            begin
                lane_reg <= '0;
            end
        end
    end

    // header low byte and lane word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_low_reg <= '0;
            word_reg       <= '0;
        end
        else
        begin
            if (cmd.take && (phase_eff != PH_HDR_HI) && (phase_eff != PH_LITERAL))
            begin
                header_low_reg <= req_data.in_byte;
            end
            if (cmd.wr)
            begin
                word_reg[{lane_reg[LANE_IDX_W-1:0], 3'b000} +: 8] <= rdata_reg;
            end
            if (cmd.emit)
            begin
                word_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take && is_copy_hdr && !bad_dist)
        begin
            src_reg <= wp_reg - back_dist;
        end
        else if (cmd.rd)
        begin
            src_reg <= src_reg + HIST_AW'(1);
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(HIST_DEPTH))
        else $error("decoded count beyond history depth");

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> stat.out_free)
        else $error("result pushed into occupied register");

    a_lane_range: assert property (@(posedge clk) disable iff (!rst_n)
        lane_reg <= LANE_CNT_W'(OUT_LANES))
        else $error("lane count overflow");

endmodule

/* sv/lz77_token_decoder_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz77_token_decoder_unit: lzss token decoder, 8-bit distance, 7-bit length
// Decodes a compressed byte stream into results of up to four bytes.
// ----------------------------------------------------------------------------
// A header byte or a literal byte is taken while the controller is idle, and
// a literal or a bad reference gives its result in the cycle after it is
// taken. A copy of length L holds off requests until its last group is
// emitted: each byte is one read and one write of the single-port 256-byte
// history memory, and each group of up to four bytes then takes an emit step
// to enter the result register. A stalled result register delays both new
// requests and the copy sequence. No clearing pass is needed after reset.
module lz77_token_decoder_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  lztd_pkg::req_item_t req_data,
    output logic                res_valid,
    input  logic                res_stall,
    output lztd_pkg::res_item_t res_data
);
    import lztd_pkg::*;

    ctrl_cmd_t   cmd;
    dpath_stat_t stat;

    lztd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    lztd_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .cmd       (cmd),
        .stat      (stat),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

endmodule

/* tb/sv/tb_lz77_token_decoder_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lz77_token_decoder_unit: self-checking bench for the lz77 token decoder
// Runs a directed token table, then random token streams mixed with abandoned
// headers and raw noise. Every result word is predicted inside the bench and
// compared in order, with random idle and stall on both channels.
// ----------------------------------------------------------------------------
module tb_lz77_token_decoder_unit;

    import lztd_pkg::*;

    localparam int RANDOM_ITEMS = 270;
    localparam int MAX_GAP      = 18;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 320;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int N_ROWS       = 25;
    localparam int MAX_WORDS    = 32;

    // how a request's results are known: from the predictor, or typed in the table
    typedef enum logic [1:0] {
        ROW_PREDICT = 2'd0,
        ROW_QUIET   = 2'd1,
        ROW_LITERAL = 2'd2,
        ROW_BADREF  = 2'd3
    } row_kind_t;

    typedef struct packed {
        logic [7:0] b;
        logic       seg;
        row_kind_t  kind;
    } stim_row_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_item_t req_data  = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    res_item_t res_data;

    // directed tokens; comments give the 16-bit header being assembled
    stim_row_t stim_table [N_ROWS] = '{
        {8'h00, 1'b1, ROW_QUIET},    // segment start, header 0x8000
        {8'h80, 1'b0, ROW_BADREF},   // distance zero
        {8'h41, 1'b0, ROW_QUIET},
        {8'h00, 1'b0, ROW_QUIET},    // high byte bit 7 clear: literal follows
        {8'hFF, 1'b0, ROW_LITERAL},
        {8'h00, 1'b0, ROW_QUIET},
        {8'h7F, 1'b0, ROW_QUIET},    // literal header, ignored bits all set
        {8'h00, 1'b0, ROW_LITERAL},
        {8'h80, 1'b0, ROW_QUIET},    // 0x8080: distance 1, length 0
        {8'h80, 1'b0, ROW_QUIET},
        {8'h85, 1'b0, ROW_QUIET},    // 0x8185: distance 3 beyond two bytes
        {8'h81, 1'b0, ROW_BADREF},
        {8'h09, 1'b0, ROW_QUIET},    // 0x8109: overlapping copy, distance 2
        {8'h81, 1'b0, ROW_PREDICT},
        {8'h7F, 1'b0, ROW_QUIET},    // 0x817F: longest length
        {8'h81, 1'b0, ROW_PREDICT},
        {8'h80, 1'b0, ROW_QUIET},    // 0xFF80: distance 255 beyond history
        {8'hFF, 1'b0, ROW_BADREF},
        {8'h7F, 1'b0, ROW_QUIET},    // 0xC07F: fills the history
        {8'hC0, 1'b0, ROW_PREDICT},
        {8'hFF, 1'b0, ROW_QUIET},    // 0xFFFF: largest distance and length
        {8'hFF, 1'b0, ROW_PREDICT},
        {8'h12, 1'b0, ROW_QUIET},    // header low, then abandoned
        {8'h81, 1'b1, ROW_QUIET},    // segment start mid token
        {8'h80, 1'b0, ROW_BADREF}    // 0x8081 on an empty history
    };

    // decoder image
    token_phase_t tok_phase = PH_HDR_LO;
    logic [7:0]   hdr_low   = 8'h00;
    logic [7:0]   hist_mem [HIST_DEPTH];
    logic [7:0]   hist_wp   = 8'h00;
    int           hist_fill = 0;
    res_item_t    step_words [MAX_WORDS];
    int           step_count;

    res_item_t decoded_words_q [$];
    row_kind_t req_kind_q [$];

    int mismatches      = 0;
    int results_checked = 0;
    int requests_taken  = 0;
    int literals_seen   = 0;
    int copies_seen     = 0;
    int copy_bytes      = 0;
    int bad_refs_seen   = 0;
    int holds_done      = 0;
    int tx_items        = 0;
    int rx_items        = 0;
    bit tx_busy         = 1'b0;
    bit rx_busy         = 1'b0;
    bit hold_request    = 1'b0;

    lz77_token_decoder_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    task automatic history_push(input logic [7:0] c);
        hist_mem[hist_wp] = c;
        hist_wp = hist_wp + 8'd1;
        if (hist_fill < HIST_DEPTH)
            hist_fill++;
    endtask

    // decodes one stream byte into step_words, updating the decoder image
    task automatic lz_decode_byte(input req_item_t r);
        logic [15:0] header;
        logic [7:0]  back_dist;
        logic [6:0]  len;
        logic [7:0]  rd_ptr;
        logic [7:0]  c;
        int          lane;
        int          k;
        res_item_t   w;
        step_count = 0;
        w = '0;
        if (r.segment_start)
        begin
            tok_phase = PH_HDR_LO;
            hdr_low   = 8'h00;
            hist_wp   = 8'h00;
            hist_fill = 0;
            for (k = 0; k < HIST_DEPTH; k++)
                hist_mem[k] = 8'h00;
        end
        case (tok_phase)
            PH_HDR_HI:
            begin
                if (!r.in_byte[7])
                    tok_phase = PH_LITERAL;
                else
                begin
                    tok_phase = PH_HDR_LO;
                    header = {r.in_byte, hdr_low};
                    back_dist = header[14:7];
                    len = header[6:0];
                    if (back_dist == 8'd0 || back_dist > hist_fill)
                    begin
                        w.bad_reference = 1'b1;
                        w.last = 1'b1;
                        step_words[0] = w;
                        step_count = 1;
                        bad_refs_seen++;
                    end
                    else
                    begin
                        copies_seen++;
                        copy_bytes += len;
                        // bytes appended as they go, so short distances repeat
                        for (k = 0; k < len; k++)
                        begin
                            lane = k % OUT_LANES;
                            if (lane == 0)
                                w = '0;
                            rd_ptr = hist_wp - back_dist;
                            c = hist_mem[rd_ptr];
                            history_push(c);
                            w.out_bytes[8*lane +: 8] = c;
                            w.byte_count = LANE_CNT_W'(lane + 1);
                            if (lane == OUT_LANES - 1 || k == len - 1)
                            begin
                                w.last = (k == len - 1);
                                step_words[step_count] = w;
                                step_count++;
                            end
                        end
                    end
                end
            end
            PH_LITERAL:
            begin
                tok_phase = PH_HDR_LO;
                history_push(r.in_byte);
                w.out_bytes[7:0] = r.in_byte;
                w.byte_count = LANE_CNT_W'(1);
                w.last = 1'b1;
                step_words[0] = w;
                step_count = 1;
                literals_seen++;
            end
            default:
            begin
                hdr_low = r.in_byte;
                tok_phase = PH_HDR_HI;
            end
        endcase
    endtask

    task automatic note_mismatch(input string what, input res_item_t want,
                                 input res_item_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] %s: expected bytes=%h count=%0d bad=%b last=%b",
                     $time, what, want.out_bytes, want.byte_count,
                     want.bad_reference, want.last,
                     "  got bytes=%h count=%0d bad=%b last=%b",
                     got.out_bytes, got.byte_count, got.bad_reference, got.last);
    endtask

    always @(posedge clk)
    begin : scoreboard
        row_kind_t kind;
        res_item_t want;
        res_item_t got;
        int        i;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                got = res_data;
                results_checked++;
                if (decoded_words_q.size() == 0)
                    note_mismatch("result with nothing pending", '0, got);
                else
                begin
                    want = decoded_words_q.pop_front();
                    if (got.out_bytes !== want.out_bytes ||
                        got.byte_count !== want.byte_count ||
                        got.bad_reference !== want.bad_reference ||
                        got.last !== want.last)
                        note_mismatch("result differs", want, got);
                end
            end
            if (req_valid && !req_stall)
            begin
                kind = (req_kind_q.size() != 0) ? req_kind_q.pop_front() : ROW_PREDICT;
                lz_decode_byte(req_data);
                requests_taken++;
                case (kind)
                    ROW_PREDICT:
                    begin
                        for (i = 0; i < step_count; i++)
                            decoded_words_q.push_back(step_words[i]);
                    end
                    ROW_LITERAL:
                    begin
                        want = '0;
                        want.out_bytes[7:0] = req_data.in_byte;
                        want.byte_count = LANE_CNT_W'(1);
                        want.last = 1'b1;
                        decoded_words_q.push_back(want);
                    end
                    ROW_BADREF:
                    begin
                        want = '0;
                        want.bad_reference = 1'b1;
                        want.last = 1'b1;
                        decoded_words_q.push_back(want);
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    task automatic send_request(input req_item_t r, input row_kind_t kind);
        int gap;
        gap = tx_busy ? 0 : $urandom_range(0, MAX_GAP);
        tx_items++;
        if (tx_items % 30 == 0)
            tx_busy = 1'($urandom_range(0, 1));
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_kind_q.push_back(kind);
        req_valid <= 1'b1;
        req_data  <= r;
        do
            @(posedge clk);
        while (!(req_valid && !req_stall));
    endtask

    // stop offering requests and wait for every pending result
    task automatic wait_for_drain;
        req_valid <= 1'b0;
        @(posedge clk);
        while (decoded_words_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : result_sink
        int gap;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                gap = HOLD_CYCLES;
                holds_done++;
            end
            else
                gap = rx_busy ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0)
            begin
                res_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            res_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(res_valid && !res_stall));
            rx_items++;
            if (rx_items % 25 == 0)
                rx_busy = 1'($urandom_range(0, 1));
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results still pending",
                 cycles, decoded_words_q.size());
        $display("Mismatches found");
        $finish;
    end

    initial
    begin : stimulus
        req_item_t   tok [4];
        int          tok_len;
        int          pick;
        int          back_dist;
        int          len;
        int          i;
        int          sent;
        int          gen_fill;
        logic [15:0] hdr;
        bit          seg_next;
        bit          hold_armed;
        bit          pause_done;
        wait (rst_n);
        @(posedge clk);
        for (i = 0; i < N_ROWS; i++)
            send_request({stim_table[i].b, stim_table[i].seg}, stim_table[i].kind);
        wait_for_drain();

        // gen_fill tracks decoded bytes so most copies stay in range
        sent = 0;
        gen_fill = 0;
        seg_next = 1'b0;
        hold_armed = 1'b0;
        pause_done = 1'b0;
        while (sent < RANDOM_ITEMS)
        begin
            if (seg_next)
                gen_fill = 0;
            pick = $urandom_range(0, 99);
            if (gen_fill == 0 && pick >= 40 && pick < 80)
                pick = 0;
            if (pick < 40)
            begin
                tok[0] = {8'($urandom), seg_next};
                tok[1] = {1'b0, 7'($urandom), 1'b0};
                tok[2] = {8'($urandom), 1'b0};
                tok_len = 3;
                if (gen_fill < HIST_DEPTH)
                    gen_fill++;
            end
            else if (pick < 88)
            begin
                if (pick < 80)
                begin
                    back_dist = $urandom_range(1, (gen_fill < 255) ? gen_fill : 255);
                    case ($urandom_range(0, 11))
                        0:       len = 0;
                        1:       len = $urandom_range(64, 127);
                        default: len = $urandom_range(1, 12);
                    endcase
                    gen_fill = (gen_fill + len > HIST_DEPTH) ? HIST_DEPTH : gen_fill + len;
                end
                else
                begin
                    // zero distance, or farther back than anything decoded
                    if (gen_fill < 255 && $urandom_range(0, 1) == 1)
                        back_dist = $urandom_range(gen_fill + 1, 255);
                    else
                        back_dist = 0;
                    len = $urandom_range(0, 127);
                end
                hdr = {1'b1, 8'(back_dist), 7'(len)};
                tok[0] = {hdr[7:0], seg_next};
                tok[1] = {hdr[15:8], 1'b0};
                tok_len = 2;
            end
            else if (pick < 94)
            begin
                // literal header left unfinished
                tok_len = $urandom_range(1, 2);
                tok[0] = {8'($urandom), seg_next};
                tok[1] = {1'b0, 7'($urandom), 1'b0};
            end
            else
            begin
                tok_len = $urandom_range(1, 4);
                for (i = 0; i < tok_len; i++)
                    tok[i] = {8'($urandom), ($urandom_range(0, 3) == 0)};
            end
            // after a broken token the next one restarts the segment
            seg_next = (pick >= 88) ? 1'b1 : ($urandom_range(0, 19) == 0);

            for (i = 0; i < tok_len; i++)
                send_request(tok[i], ROW_PREDICT);
            sent += tok_len;

            if (!hold_armed && sent >= 90)
            begin
                hold_armed = 1'b1;
                hold_request = 1'b1;
                tx_busy = 1'b1;
            end
            if (!pause_done && sent >= 180)
            begin
                pause_done = 1'b1;
                wait_for_drain();
            end
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("decoded %0d stream bytes: %0d literals, %0d copies of %0d bytes, %0d bad refs",
                 requests_taken, literals_seen, copies_seen, copy_bytes, bad_refs_seen);
        $display("checked %0d result words, %0d long receiver hold-offs, %0d wrong",
                 results_checked, holds_done, mismatches);
        if (mismatches == 0 && decoded_words_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
